@@ src/humidity_sensor_frame_decoder_unit_defines.svh @@
// Assertion macros used by the top RTL file of the frame decoder.
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_UNIT_DEFINES_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define HSFD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsfd assertion failed");

`define HSFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsfd assertion failed");

`else

`define HSFD_ASSERT_IMPL(lbl, clk, rst, ante, cons)

`define HSFD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ src/hsfd_pkg.sv @@
package hsfd_pkg;

  // Decoded request fields.
  typedef struct packed {
    logic               operation;
    logic [7:0]         data_high;
    logic [7:0]         data_low;
    logic [7:0]         check_byte;
    logic               compensate;
    logic signed [14:0] ambient_temp;
  } hsfd_req_t;

  // Result fields.
  typedef struct packed {
    logic               status;
    logic [15:0]        raw_word;
    logic signed [14:0] value;
  } hsfd_res_t;

  localparam logic       OP_TEMP     = 1'b0;
  localparam logic       OP_HUMID    = 1'b1;
  localparam logic       STATUS_OK   = 1'b0;
  localparam logic       STATUS_CRC  = 1'b1;

  localparam logic [7:0] CRC_POLY    = 8'h31;

  localparam logic [14:0] T_MUL      = 15'd17572;
  localparam logic [13:0] RH_MUL     = 14'd12500;
  localparam logic signed [16:0] T_OFFSET  = 17'sd4685;
  localparam logic signed [16:0] RH_OFFSET = 17'sd600;

  // Compensation floor((t - 2500) * 15 / 100) with u = t + 16384 becomes
  // floor((15 * u + 40) / 100) - 2833. The division by 100 is a multiply by
  // ceil(2^26 / 100) = 671089 followed by a 26-bit shift, exact for the
  // whole range of u.
  localparam logic [23:0] COMP_RECIP = 24'd10066335;  // 15 * 671089
  localparam logic [24:0] COMP_BIAS  = 25'd26843560;  // 40 * 671089
  localparam int          COMP_SHIFT = 26;
  localparam logic signed [16:0] COMP_ZERO = 17'sd2833;

  // Eight MSB-first CRC steps over one byte already folded into the CRC.
  function automatic logic [7:0] crc8_byte(input logic [7:0] seed);
    logic [7:0] crc;
    crc = seed;
    for (int i = 0; i < 8; i++) begin
      if (crc[7]) begin
        crc = {crc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

@@ src/hsfd_convert.sv @@
module hsfd_convert
  import hsfd_pkg::*;
(
  input  hsfd_req_t req,
  output hsfd_res_t res
);

  logic [15:0]        word;
  logic [7:0]         crc;
  logic [30:0]        t_prod;
  logic [29:0]        h_prod;
  logic [14:0]        t_u;
  logic [38:0]        c_prod;
  logic [12:0]        c_quot;
  logic signed [16:0] t_val;
  logic signed [16:0] h_val;
  logic signed [16:0] c_val;
  logic signed [16:0] sel_val;

  assign word = {req.data_high, req.data_low};

  // With a zero initial value the high byte goes straight in.
  assign crc = crc8_byte(crc8_byte(req.data_high) ^ req.data_low);

  assign t_prod = 31'(word) * 31'(T_MUL);
  assign h_prod = 30'(word) * 30'(RH_MUL);

  // Offset binary form of the signed ambient temperature.
  assign t_u    = {~req.ambient_temp[14], req.ambient_temp[13:0]};
  assign c_prod = 39'(t_u) * 39'(COMP_RECIP) + 39'(COMP_BIAS);
  assign c_quot = c_prod[38:COMP_SHIFT];

  assign t_val = $signed({2'b00, t_prod[30:16]}) - T_OFFSET;
  assign c_val = $signed({4'b0000, c_quot}) - COMP_ZERO;

  always_comb begin
    h_val = $signed({3'b000, h_prod[29:16]}) - RH_OFFSET;
    if (req.compensate) begin
      h_val = h_val + c_val;
    end
  end

  assign sel_val = (req.operation == OP_HUMID) ? h_val : t_val;

  always_comb begin
    res.raw_word = word;
    if (crc == req.check_byte) begin
      res.status = STATUS_OK;
      res.value  = sel_val[14:0];
    end else begin
      res.status = STATUS_CRC;
      res.value  = '0;
    end
  end

endmodule

@@ src/humidity_sensor_frame_decoder_unit.sv @@
// Sensor frame decoder: checks the CRC-8 of a two-byte measurement and turns
// it into hundredths of a degree Celsius or of a percent relative humidity.
// Input channel s_axis_*: one request per frame; s_axis_tuser selects
// temperature (0) or humidity (1), s_axis_tdata carries the bytes and the
// optional compensation temperature.
// Output channel m_axis_*: one result per request, in order; m_axis_tuser is
// the status (1 on CRC mismatch, value then reads zero).
// The request lands in an input register, the CRC and the constant
// multiplies run in the logic between, and the result register presents it.
// Throughput is one request per cycle while m_axis_tready stays high, set by
// that single register-to-register pass.
// When a result waits and m_axis_tready is low the result register holds; an
// empty input register still takes one more request, after which s_axis_tready drops.
// Reset empties both registers; there is no other state.
`include "humidity_sensor_frame_decoder_unit_defines.svh"

module humidity_sensor_frame_decoder_unit
  import hsfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] data_high, [15:8] data_low, [23:16] check_byte, [24] compensate,
  // [39:25] ambient_temp
  input  logic [39:0] s_axis_tdata,
  // [0] operation
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] raw_word, [30:16] value, [31] zero
  output logic [31:0] m_axis_tdata,
  // [0] status
  output logic        m_axis_tuser
);

  logic        in_valid;
  hsfd_req_t   in_q;
  logic        out_valid;
  hsfd_res_t   out_q;
  hsfd_res_t   res;
  logic        out_free;
  logic [15:0] in_word;

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_free;
  assign in_word       = {in_q.data_high, in_q.data_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.operation    <= s_axis_tuser;
      in_q.data_high    <= s_axis_tdata[7:0];
      in_q.data_low     <= s_axis_tdata[15:8];
      in_q.check_byte   <= s_axis_tdata[23:16];
      in_q.compensate   <= s_axis_tdata[24];
      in_q.ambient_temp <= s_axis_tdata[39:25];
    end
    if (in_valid && out_free) begin
      out_q <= res;
    end
  end

  hsfd_convert u_convert (
    .req (in_q),
    .res (res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_q.value, out_q.raw_word};
  assign m_axis_tuser  = out_q.status;

  `HSFD_ASSERT_NEXT(a_load_in, clk, rst, s_axis_tvalid && s_axis_tready, in_valid)
  `HSFD_ASSERT_NEXT(a_hold_in, clk, rst, in_valid && !out_free, in_valid)
  `HSFD_ASSERT_NEXT(a_advance, clk, rst, in_valid && out_free, m_axis_tvalid)
  `HSFD_ASSERT_NEXT(a_raw_word, clk, rst, in_valid && out_free, out_q.raw_word == $past(in_word))
  `HSFD_ASSERT_IMPL(a_err_zero, clk, rst, m_axis_tvalid && (out_q.status == STATUS_CRC), out_q.value == '0)

endmodule

@@ tb/sv/tb_humidity_sensor_frame_decoder_unit.sv @@
module tb_humidity_sensor_frame_decoder_unit;
  import hsfd_pkg::*;

  // Keeps the readings the decoder owes us, oldest first, and grades each
  // one that comes out.
  class reading_scoreboard;
    hsfd_res_t expected_readings[$];
    int        errors;

    static function logic [7:0] crc_of(logic [15:0] word);
      logic [7:0] crc;
      logic       feedback;
      crc = 8'h00;
      for (int i = 15; i >= 0; i--) begin
        feedback = crc[7] ^ word[i];
        crc = {crc[6:0], 1'b0};
        if (feedback) begin
          crc = crc ^ CRC_POLY;
        end
      end
      return crc;
    endfunction

    static function int floor_hundredths(int num);
      if (num >= 0) begin
        return num / 100;
      end
      return -((-num + 99) / 100);
    endfunction

    static function hsfd_res_t decode_frame(hsfd_req_t req);
      hsfd_res_t   res;
      logic [15:0] word;
      int          reading;
      word = {req.data_high, req.data_low};
      reading = 0;
      res.raw_word = word;
      res.status = STATUS_OK;
      if (crc_of(word) != req.check_byte) begin
        res.status = STATUS_CRC;
      end else if (req.operation == OP_TEMP) begin
        reading = ((int'(word) * 17572) >> 16) - 4685;
      end else begin
        reading = ((int'(word) * 12500) >> 16) - 600;
        // Compensation is taken relative to 25 C and rounds toward minus infinity.
        if (req.compensate) begin
          reading = reading + floor_hundredths((int'(req.ambient_temp) - 2500) * 15);
        end
      end
      res.value = reading[14:0];
      return res;
    endfunction

    function void note_request(hsfd_req_t req);
      expected_readings.push_back(decode_frame(req));
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    function void check_result(hsfd_res_t got);
      hsfd_res_t want;
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d raw %0h value %0d",
                 $time, got.status, got.raw_word, got.value);
        errors++;
        return;
      end
      want = expected_readings.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.raw_word !== want.raw_word) begin
        $display("%0t: raw_word expected %0h, got %0h", $time, want.raw_word, got.raw_word);
        errors++;
      end
      if (got.value !== want.value) begin
        $display("%0t: value expected %0d, got %0d", $time, want.value, got.value);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  reading_scoreboard sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off_req;

  humidity_sensor_frame_decoder_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk = ~clk;

  function automatic hsfd_req_t frame_for(logic op, logic [15:0] word, logic [7:0] crc_flip,
                                          logic comp, int ambient);
    hsfd_req_t req;
    req.operation = op;
    req.data_high = word[15:8];
    req.data_low = word[7:0];
    req.check_byte = reading_scoreboard::crc_of(word) ^ crc_flip;
    req.compensate = comp;
    req.ambient_temp = 15'(ambient);
    return req;
  endfunction

  // Mostly frames with a good CRC; the rest carry a flipped bit or a random
  // check byte. The ambient temperature now and then leaves the sensor range.
  function automatic hsfd_req_t random_frame();
    hsfd_req_t   req;
    logic [15:0] word;
    int          pick;
    word = 16'($urandom_range(65535));
    pick = $urandom_range(99);
    req = frame_for(1'($urandom_range(1)), word, 8'h00, 1'($urandom_range(1)), 0);
    if (pick < 8) begin
      req.check_byte = req.check_byte ^ 8'(1 << $urandom_range(7));
    end else if (pick < 15) begin
      req.check_byte = 8'($urandom_range(255));
    end
    if ($urandom_range(99) < 85) begin
      req.ambient_temp = 15'($urandom_range(17572) - 4685);
    end else begin
      req.ambient_temp = 15'($urandom_range(32767));
    end
    return req;
  endfunction

  task automatic send_request(input hsfd_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {req.ambient_temp, req.compensate, req.check_byte, req.data_low,
                     req.data_high};
    s_axis_tuser <= req.operation;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(req);
  endtask

  task automatic wait_for_readings();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_frames(input int count);
    for (int n = 0; n < count; n++) begin
      send_request(random_frame());
    end
  endtask

  // Result side: grade accepted results, then pick tready for the next edge.
  initial begin
    hsfd_res_t seen;
    int        hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        seen.status = m_axis_tuser;
        seen.raw_word = m_axis_tdata[15:0];
        seen.value = m_axis_tdata[30:16];
        sb.check_result(seen);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = 64;
      end
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    send_idle_pct = 32;
    recv_idle_pct = 54;
    hold_off_req = 1'b0;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= OP_TEMP;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_request(frame_for(OP_TEMP, 16'h0000, 8'h00, 1'b0, 0));
    send_request(frame_for(OP_TEMP, 16'hFFFF, 8'h00, 1'b0, 0));
    send_request(frame_for(OP_HUMID, 16'h0000, 8'h00, 1'b0, 0));
    send_request(frame_for(OP_HUMID, 16'hFFFF, 8'h00, 1'b0, 0));
    send_request(frame_for(OP_HUMID, 16'hFFFF, 8'h00, 1'b1, 12887));
    send_request(frame_for(OP_HUMID, 16'h0000, 8'h00, 1'b1, -4685));
    send_request(frame_for(OP_HUMID, 16'h0000, 8'h00, 1'b1, -16384));
    send_request(frame_for(OP_HUMID, 16'hFFFF, 8'h00, 1'b1, 16383));
    send_request(frame_for(OP_HUMID, 16'h7A3C, 8'h00, 1'b1, 2500));
    send_request(frame_for(OP_HUMID, 16'h7A3C, 8'h00, 1'b1, 2499));
    send_request(frame_for(OP_HUMID, 16'h6666, 8'h00, 1'b1, 2401));
    // A temperature frame must ignore the compensation inputs.
    send_request(frame_for(OP_TEMP, 16'h6666, 8'h00, 1'b1, 12887));
    send_request(frame_for(OP_TEMP, 16'hAAAA, 8'h00, 1'b1, -16384));
    send_request(frame_for(OP_HUMID, 16'h5555, 8'h00, 1'b0, 16383));
    // CRC mismatches, including check bytes of all ones and all zeros.
    send_request(frame_for(OP_TEMP, 16'h1234, 8'h01, 1'b0, 0));
    send_request(frame_for(OP_HUMID, 16'h1234, 8'h80, 1'b1, 12887));
    send_request(frame_for(OP_HUMID, 16'h0000, 8'hFF, 1'b1, -4685));
    send_request(frame_for(OP_TEMP, 16'hFFFF, reading_scoreboard::crc_of(16'hFFFF), 1'b0, 0));
    send_request(frame_for(OP_HUMID, 16'h8001, 8'h10, 1'b0, 0));

    send_random_frames(240);
    wait_for_readings();

    send_idle_pct = 54;
    recv_idle_pct = 32;
    send_random_frames(250);
    wait_for_readings();

    // No idling; the receiver first holds off long enough to back up the input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req = 1'b1;
    send_random_frames(250);
    wait_for_readings();

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_humidity_sensor_frame_decoder_unit passed");
    end else begin
      $display("tb_humidity_sensor_frame_decoder_unit failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_humidity_sensor_frame_decoder_unit failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/hsfd_pkg.sv
src/hsfd_convert.sv
src/humidity_sensor_frame_decoder_unit.sv
tb/sv/tb_humidity_sensor_frame_decoder_unit.sv
